FILE: rtl/mtf_pkg.sv
// Shared types and constants for the move-to-front ID list.
package mtf_pkg;

   // Width of the entry_id field at the ports.
   localparam int unsigned ENTRY_ID_W = 16;

   // Width of the request tdata bus: operation and entry_id, padded to whole bytes.
   localparam int unsigned REQ_TDATA_W = 24;

   // Width of the response tdata bus: the result fields, padded to whole bytes.
   localparam int unsigned RSP_TDATA_W = 16;

   typedef enum logic [1:0] {
      OP_MARK    = 2'd0,
      OP_RELEASE = 2'd1,
      OP_LOOKUP  = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_SHIFT_DN,
      ST_SHIFT_UP,
      ST_PLACE,
      ST_DONE
   } state_type;

   // One result item, with found in the lowest bit.
   typedef struct packed {
      logic       dropped_oldest;
      logic [4:0] entry_count;
      logic [3:0] position;
      logic       found;
   } rsp_type;

   localparam int unsigned RSP_BITS = $bits(rsp_type);

endpackage

FILE: rtl/move_to_front_id_list.sv
// Move-to-front ID list top level: stream ports, list memory and result register.
// Each operation scans the list, and a mark or release may then shift it, stepping
// through the memory read port one entry per cycle.
// Throughput: one operation at a time; the next request is taken once the current
// result reaches the output register, which may still wait on rsp_tready.
// Reset: synchronous, active high; empties the list and clears the output valid.
module move_to_front_id_list #(
   parameter int unsigned DEPTH   = 16,
   parameter int unsigned ID_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // Fields from bit 0: operation [1:0], entry_id [17:2], zero pad [23:18].
   input  logic [mtf_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // Fields from bit 0: found [0], position [4:1], entry_count [9:5],
   // dropped_oldest [10], zero pad [15:11].
   output logic [mtf_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   localparam int unsigned IW = (ID_BITS < mtf_pkg::ENTRY_ID_W) ? ID_BITS
                                                                : mtf_pkg::ENTRY_ID_W;
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic             out_valid_ff, out_valid_in;
   mtf_pkg::rsp_type out_data_ff;
   logic             out_free;
   logic             res_valid;
   mtf_pkg::rsp_type res;
   mtf_pkg::op_type  req_op;
   logic [IW-1:0]    req_id;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [IW-1:0]    wr_data;
   logic [AW-1:0]    rd_addr;
   logic [IW-1:0]    rd_data;

   assign req_op = mtf_pkg::op_type'(req_tdata[1:0]);
   assign req_id = req_tdata[IW+1:2];

   mtf_ram #(
      .DEPTH (DEPTH),
      .WIDTH (IW),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mtf_seq #(
      .DEPTH (DEPTH),
      .IW    (IW),
      .AW    (AW),
      .CW    (CW)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_op     (req_op),
      .in_id     (req_id),
      .out_free  (out_free),
      .res_valid (res_valid),
      .res       (res),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   // The result register can take a new result when empty or when its transfer completes.
   assign out_free     = !out_valid_ff || rsp_tready;
   assign out_valid_in = res_valid || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (res_valid) begin
         out_data_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(mtf_pkg::RSP_TDATA_W - mtf_pkg::RSP_BITS){1'b0}}, out_data_ff};

endmodule

FILE: rtl/mtf_ram.sv
// Simple dual-port list memory with one write port and a registered read port.
module mtf_ram #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned WIDTH = 16,
   parameter int unsigned AW    = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/mtf_seq.sv
// Operation sequencer: scans the list memory for the ID, then shifts entries to update it for a mark or release.
module mtf_seq #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned IW    = 16,
   parameter int unsigned AW    = 4,
   parameter int unsigned CW    = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  mtf_pkg::op_type    in_op,
   input  logic [IW-1:0]      in_id,
   input  logic               out_free,
   output logic               res_valid,
   output mtf_pkg::rsp_type   res,
   output logic               wr_en,
   output logic [AW-1:0]      wr_addr,
   output logic [IW-1:0]      wr_data,
   output logic [AW-1:0]      rd_addr,
   input  logic [IW-1:0]      rd_data
);

   mtf_pkg::state_type state_ff, state_in;
   mtf_pkg::op_type    op_ff, op_in;
   logic [IW-1:0]      id_ff, id_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic               hit_ff, hit_in;
   logic               drop_ff, drop_in;
   logic [CW-1:0]      cnt_last;
   logic [CW-1:0]      idx_ext;
   logic [CW-1:0]      pos_ext;

   assign cnt_last = cnt_ff - CW'(1);
   assign idx_ext  = CW'(idx_ff);
   assign pos_ext  = CW'(pos_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mtf_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      op_ff   <= op_in;
      id_ff   <= id_in;
      idx_ff  <= idx_in;
      pos_ff  <= pos_in;
      hit_ff  <= hit_in;
      drop_ff <= drop_in;
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      id_in     = id_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      hit_in    = hit_ff;
      drop_in   = drop_ff;
      in_ready  = 1'b0;
      res_valid = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = rd_data;
      rd_addr   = idx_ff;

      unique case (state_ff)
         mtf_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            rd_addr  = '0;
            if (in_valid) begin
               op_in   = in_op;
               id_in   = in_id;
               hit_in  = 1'b0;
               pos_in  = '0;
               drop_in = 1'b0;
               idx_in  = '0;
               state_in = (cnt_ff == '0) ? mtf_pkg::ST_DECIDE : mtf_pkg::ST_SCAN;
            end
         end

         // Read data here belongs to entry idx_ff; the next read is issued ahead.
         mtf_pkg::ST_SCAN: begin
            if (rd_data == id_ff) begin
               hit_in   = 1'b1;
               pos_in   = idx_ff;
               state_in = mtf_pkg::ST_DECIDE;
            end else if (idx_ext == cnt_last) begin
               state_in = mtf_pkg::ST_DECIDE;
            end else begin
               idx_in  = idx_ff + AW'(1);
               rd_addr = idx_ff + AW'(1);
            end
         end

         mtf_pkg::ST_DECIDE: begin
            unique case (op_ff)
               mtf_pkg::OP_LOOKUP: begin
                  state_in = mtf_pkg::ST_DONE;
               end
               mtf_pkg::OP_CLEAR: begin
                  cnt_in   = '0;
                  state_in = mtf_pkg::ST_DONE;
               end
               mtf_pkg::OP_RELEASE: begin
                  if (!hit_ff) begin
                     state_in = mtf_pkg::ST_DONE;
                  end else if (pos_ext < cnt_last) begin
                     idx_in   = pos_ff + AW'(1);
                     rd_addr  = pos_ff + AW'(1);
                     state_in = mtf_pkg::ST_SHIFT_UP;
                  end else begin
                     cnt_in   = cnt_last;
                     state_in = mtf_pkg::ST_DONE;
                  end
               end
               mtf_pkg::OP_MARK: begin
                  if (hit_ff) begin
                     if (pos_ff != '0) begin
                        idx_in   = pos_ff - AW'(1);
                        rd_addr  = pos_ff - AW'(1);
                        state_in = mtf_pkg::ST_SHIFT_DN;
                     end else begin
                        state_in = mtf_pkg::ST_PLACE;
                     end
                  end else if (cnt_ff == '0) begin
                     cnt_in   = CW'(1);
                     state_in = mtf_pkg::ST_PLACE;
                  end else if (cnt_ff >= CW'(DEPTH)) begin
                     // The back entry falls off; the shift starts one above it.
                     drop_in  = 1'b1;
                     idx_in   = AW'(DEPTH - 2);
                     rd_addr  = AW'(DEPTH - 2);
                     state_in = mtf_pkg::ST_SHIFT_DN;
                  end else begin
                     cnt_in   = cnt_ff + CW'(1);
                     idx_in   = cnt_last[AW-1:0];
                     rd_addr  = cnt_last[AW-1:0];
                     state_in = mtf_pkg::ST_SHIFT_DN;
                  end
               end
               default: begin
                  state_in = mtf_pkg::ST_DONE;
               end
            endcase
         end

         // Move entry idx_ff one place toward the back, working from back to front.
         mtf_pkg::ST_SHIFT_DN: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff + AW'(1);
            if (idx_ff == '0) begin
               state_in = mtf_pkg::ST_PLACE;
            end else begin
               idx_in  = idx_ff - AW'(1);
               rd_addr = idx_ff - AW'(1);
            end
         end

         // Move entry idx_ff one place toward the front, closing the released gap.
         mtf_pkg::ST_SHIFT_UP: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff - AW'(1);
            if (idx_ext == cnt_last) begin
               cnt_in   = cnt_last;
               state_in = mtf_pkg::ST_DONE;
            end else begin
               idx_in  = idx_ff + AW'(1);
               rd_addr = idx_ff + AW'(1);
            end
         end

         mtf_pkg::ST_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = id_ff;
            state_in = mtf_pkg::ST_DONE;
         end

         mtf_pkg::ST_DONE: begin
            if (out_free) begin
               res_valid = 1'b1;
               state_in  = mtf_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = mtf_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      res.found          = hit_ff;
      res.position       = hit_ff ? 4'(pos_ff) : 4'd0;
      res.entry_count    = 5'(cnt_ff);
      res.dropped_oldest = drop_ff;
   end

endmodule

FILE: bench/move_to_front_id_list_tb.sv
// Self-checking testbench for the move-to-front ID list: directed and random stream traffic.
module move_to_front_id_list_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ID_W        = mtf_pkg::ENTRY_ID_W;
   localparam int unsigned LIST_DEPTH  = 16;
   localparam int unsigned IDLE_LIMIT  = 2000;
   localparam int unsigned DRAIN_TICKS = 2 * LIST_DEPTH + 8;
   localparam int unsigned RANDOM_ITEMS = 900;

   // Tracks the list contents and holds the results still owed by the block.
   class id_list_tracker;
      logic [ID_W-1:0]       held_ids [LIST_DEPTH];
      int unsigned           held;
      mtf_pkg::rsp_type      owed [$];
      int unsigned           errors;
      int unsigned           op_seen [4];
      int unsigned           hits;
      int unsigned           drops;
      int unsigned           results;

      function new();
         held = 0;
         errors = 0;
         hits = 0;
         drops = 0;
         results = 0;
         foreach (op_seen[i]) op_seen[i] = 0;
      endfunction

      // Apply one accepted request to the tracked list and queue its result.
      function void note_request(mtf_pkg::op_type op, logic [ID_W-1:0] id);
         mtf_pkg::rsp_type r;
         bit          hit;
         int unsigned pos;
         int unsigned top;
         hit = 1'b0;
         pos = 0;
         for (int unsigned i = 0; i < held; i++) begin
            if (!hit && held_ids[i] == id) begin
               hit = 1'b1;
               pos = i;
            end
         end
         r = '0;
         r.found = hit;
         r.position = hit ? pos[3:0] : 4'd0;
         unique case (op)
            mtf_pkg::OP_MARK: begin
               if (hit) begin
                  for (int unsigned i = pos; i + 1 < held; i++) held_ids[i] = held_ids[i + 1];
                  held--;
               end else if (held >= LIST_DEPTH) begin
                  r.dropped_oldest = 1'b1;
                  held = LIST_DEPTH - 1;
               end
               top = (held >= LIST_DEPTH) ? LIST_DEPTH - 1 : held;
               for (int unsigned k = top; k > 0; k--) held_ids[k] = held_ids[k - 1];
               held_ids[0] = id;
               if (held < LIST_DEPTH) held++;
            end
            mtf_pkg::OP_RELEASE: begin
               if (hit) begin
                  for (int unsigned i = pos; i + 1 < held; i++) held_ids[i] = held_ids[i + 1];
                  held--;
               end
            end
            mtf_pkg::OP_LOOKUP: begin
            end
            default: begin
               held = 0;
            end
         endcase
         r.entry_count = held[4:0];
         op_seen[op]++;
         if (hit) hits++;
         if (r.dropped_oldest) drops++;
         owed = {owed, r};
      endfunction

      function void check_response(logic [mtf_pkg::RSP_TDATA_W-1:0] data);
         mtf_pkg::rsp_type got;
         mtf_pkg::rsp_type want;
         got = mtf_pkg::rsp_type'(data[mtf_pkg::RSP_BITS-1:0]);
         results++;
         if (owed.size() == 0) begin
            $error("response transfer 0x%04h arrived with no request outstanding", data);
            errors++;
         end else begin
            want = owed.pop_front();
            if (got.found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, got.found);
               errors++;
            end
            if (got.position !== want.position) begin
               $error("position: expected %0d, got %0d", want.position, got.position);
               errors++;
            end
            if (got.entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
               errors++;
            end
            if (got.dropped_oldest !== want.dropped_oldest) begin
               $error("dropped_oldest: expected %0d, got %0d",
                      want.dropped_oldest, got.dropped_oldest);
               errors++;
            end
         end
      endfunction

      function int unsigned outstanding();
         return owed.size();
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [mtf_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [mtf_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   id_list_tracker tracker = new();
   int unsigned    idle_cycles;
   logic [ID_W-1:0] id_pool [24];

   move_to_front_id_list #(
      .DEPTH   (LIST_DEPTH),
      .ID_BITS (ID_W)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Present one request and hold it until the block takes it.
   task automatic send_request(mtf_pkg::op_type op, logic [ID_W-1:0] id, int unsigned gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(mtf_pkg::REQ_TDATA_W - ID_W - 2){1'b0}}, id, op};
      do @(posedge clock); while (!req_tready);
      tracker.note_request(op, id);
   endtask

   // Hold the request side until every owed result has been taken.
   task automatic wait_results_done();
      req_tvalid <= 1'b0;
      while (tracker.outstanding() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // Receiver: ready stalls of random length between runs of random length.
   initial begin
      int unsigned stall;
      int unsigned run;
      do @(posedge clock); while (reset);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         run = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 4);
         repeat (run) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_response(rsp_tdata);
   end

   // Watchdog on cycles without any transfer on either side.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [ID_W-1:0]       id;
      mtf_pkg::op_type       op;
      int unsigned           r;
      bit                    steady;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      idle_cycles = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: misses on an empty list, a move to front, a hit release,
      // clear of the whole list, then a full list with a drop and a lookup at the back.
      send_request(mtf_pkg::OP_LOOKUP, 16'h0000, pick_gap());
      send_request(mtf_pkg::OP_RELEASE, 16'h0005, pick_gap());
      send_request(mtf_pkg::OP_MARK, 16'h0000, pick_gap());
      send_request(mtf_pkg::OP_MARK, 16'hFFFF, pick_gap());
      send_request(mtf_pkg::OP_MARK, 16'h0000, pick_gap());
      send_request(mtf_pkg::OP_RELEASE, 16'hFFFF, pick_gap());
      send_request(mtf_pkg::OP_CLEAR, 16'h0000, pick_gap());
      for (int unsigned k = 0; k < LIST_DEPTH; k++) begin
         send_request(mtf_pkg::OP_MARK, ID_W'(16'h8000 | (k * 16'h0111)), pick_gap());
      end
      send_request(mtf_pkg::OP_MARK, 16'h7FFE, pick_gap());
      send_request(mtf_pkg::OP_LOOKUP, 16'h8111, pick_gap());
      wait_results_done();

      // Random: mostly IDs from a small pool so that hits, moves and drops are
      // frequent, with some IDs drawn from the whole range.
      steady = 1'b0;
      for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 150 == 0) begin
            foreach (id_pool[i]) id_pool[i] = ID_W'($urandom());
         end
         if (n % 100 == 0) steady = ($urandom_range(0, 2) == 0);
         if (n % 200 == 199) wait_results_done();
         r = $urandom_range(0, 99);
         if (r < 50) op = mtf_pkg::OP_MARK;
         else if (r < 65) op = mtf_pkg::OP_RELEASE;
         else if (r < 97) op = mtf_pkg::OP_LOOKUP;
         else op = mtf_pkg::OP_CLEAR;
         if ($urandom_range(0, 99) < 85) id = id_pool[5'($urandom_range(0, 23))];
         else id = ID_W'($urandom());
         send_request(op, id, steady ? 0 : pick_gap());
      end
      req_tvalid <= 1'b0;

      while (tracker.outstanding() != 0) @(negedge clock);
      repeat (DRAIN_TICKS) @(posedge clock);

      $display("Sent %0d requests: %0d marks, %0d releases, %0d lookups, %0d clears.",
               tracker.op_seen[mtf_pkg::OP_MARK] + tracker.op_seen[mtf_pkg::OP_RELEASE]
               + tracker.op_seen[mtf_pkg::OP_LOOKUP] + tracker.op_seen[mtf_pkg::OP_CLEAR],
               tracker.op_seen[mtf_pkg::OP_MARK], tracker.op_seen[mtf_pkg::OP_RELEASE],
               tracker.op_seen[mtf_pkg::OP_LOOKUP], tracker.op_seen[mtf_pkg::OP_CLEAR]);
      $display("Checked %0d results, %0d of them hits and %0d back-entry drops.",
               tracker.results, tracker.hits, tracker.drops);
      if (tracker.errors == 0 && tracker.outstanding() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/mtf_pkg.sv
rtl/mtf_ram.sv
rtl/mtf_seq.sv
rtl/move_to_front_id_list.sv
bench/move_to_front_id_list_tb.sv
